>>> rtl/cdq_pkg.sv
// Shared types and constants for the circular deque with search.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DATA_W       = 32;
  localparam int ACTION_W     = 3;
  localparam int STATUS_W     = 2;
  localparam int POSITION_W   = 5;
  localparam int CAPACITY_DEF = 16;

  // action codes of an input item
  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_DUMP      = 3'd5
  } action_t;

  // status codes of a result item
  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] element;
    logic [POSITION_W-1:0]    position;
    logic                     last;
  } out_item_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,   // take left neighbor (toward back)
    CELL_SHL  = 2'd2,   // take right neighbor (toward front, wraps)
    CELL_PUT  = 2'd3    // selected cell loads the insert value
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     put_en;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

endpackage

`default_nettype wire

>>> rtl/cdq_cell.sv
// One storage cell of the deque chain.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell (
  input  wire                                 clk,
  input  wire cdq_pkg::cell_ctrl_t            ctrl,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] ins_val,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] left_val,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] right_val,
  output logic signed [cdq_pkg::DATA_W-1:0]      val
);

  logic signed [cdq_pkg::DATA_W-1:0] val_r;
  logic signed [cdq_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      cdq_pkg::CELL_SHR: val_nxt = left_val;
      cdq_pkg::CELL_SHL: val_nxt = right_val;
      cdq_pkg::CELL_PUT: if (ctrl.put_en) val_nxt = ins_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

>>> rtl/circular_deque_with_search_top.sv
// Top level: bounded deque with search and dump, built as a ring of cells.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_stall   | cdq_pkg::in_item_t  (action, value)
//  out_    | output    | out_valid / out_stall | cdq_pkg::out_item_t (status,
//          |           |                      |   element, position, last)
//
// Inserts and deletes are taken in IDLE and their result goes straight into the
// output register.
// Search and dump rotate the whole cell ring once after acceptance; cell 0 is
// inspected at each rotation step, so the walk length is set by the ring size.
// The ring ends in its original order.
// A stalled output register freezes the walk; a new item is taken only in IDLE
// with the output register free or being drained.
// Synchronous active-low reset empties the store; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_with_search_top #(
  parameter int CAPACITY = cdq_pkg::CAPACITY_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire cdq_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output cdq_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);

  // control state
  cdq_pkg::state_t   state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic              dump_r, dump_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic signed [cdq_pkg::DATA_W-1:0]  key_r, key_nxt;
  logic [cdq_pkg::POSITION_W-1:0]     pos_r, pos_nxt;
  cdq_pkg::out_item_t                 out_data_r, out_data_nxt;

  // ring
  cdq_pkg::cell_op_t                  cell_op;
  logic signed [cdq_pkg::DATA_W-1:0]  cell_val [CAPACITY];
  cdq_pkg::cell_ctrl_t                cell_ctrl [CAPACITY];

  logic can_out;
  logic full, empty;
  logic [OCC_W-1:0] cnt_ext;
  logic [OCC_W-1:0] cnt_inc;
  logic in_range;
  logic hit;
  cdq_pkg::out_item_t res;

  assign can_out = !out_valid_r || !out_stall;
  assign full    = (occ_r == OCC_W'(CAPACITY));
  assign empty   = (occ_r == '0);
  assign cnt_ext = OCC_W'(cnt_r);
  assign cnt_inc = cnt_ext + OCC_W'(1);
  assign in_range = (cnt_ext < occ_r);
  assign hit     = in_range && !found_r && (cell_val[0] == key_r);

  // ----- cell chain: index 0 is the front, wrap from 0 back to the end -----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i].op     = cell_op;
    assign cell_ctrl[i].put_en = (occ_r == OCC_W'(i));

    cdq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .ins_val   (in_data.value),
      .left_val  ((i == 0) ? in_data.value : cell_val[(i + CAPACITY - 1) % CAPACITY]),
      .right_val (cell_val[(i + 1) % CAPACITY]),
      .val       (cell_val[i])
    );
  end

  // ----- next state, ring control and result -----
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    dump_nxt      = dump_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cell_op       = cdq_pkg::CELL_HOLD;
    in_stall      = 1'b1;

    res.status   = cdq_pkg::STS_OK;
    res.element  = '0;
    res.position = '0;
    res.last     = 1'b1;

    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        in_stall = !can_out;
        if (in_valid && can_out) begin
          unique case (in_data.action) inside
            cdq_pkg::ACT_INS_FRONT: begin
              if (full) begin
                res.status = cdq_pkg::STS_FULL;
              end else begin
                cell_op = cdq_pkg::CELL_SHR;
                occ_nxt = occ_r + OCC_W'(1);
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
            cdq_pkg::ACT_INS_BACK: begin
              if (full) begin
                res.status = cdq_pkg::STS_FULL;
              end else begin
                cell_op = cdq_pkg::CELL_PUT;
                occ_nxt = occ_r + OCC_W'(1);
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
            cdq_pkg::ACT_DEL_FRONT: begin
              if (empty) begin
                res.status = cdq_pkg::STS_EMPTY;
              end else begin
                cell_op = cdq_pkg::CELL_SHL;
                occ_nxt = occ_r - OCC_W'(1);
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
            cdq_pkg::ACT_DEL_BACK: begin
              if (empty) begin
                res.status = cdq_pkg::STS_EMPTY;
              end else begin
                occ_nxt = occ_r - OCC_W'(1);
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
            cdq_pkg::ACT_SEARCH, cdq_pkg::ACT_DUMP: begin
              if (empty) begin
                res.status    = cdq_pkg::STS_EMPTY;
                out_valid_nxt = 1'b1;
                out_data_nxt  = res;
              end else begin
                state_nxt = cdq_pkg::S_WALK;
                cnt_nxt   = '0;
                found_nxt = 1'b0;
                pos_nxt   = '0;
                key_nxt   = in_data.value;
                dump_nxt  = (in_data.action == cdq_pkg::ACT_DUMP);
              end
            end
            default: ;  // unused codes: no result
          endcase
        end
      end

      cdq_pkg::S_WALK: begin
        // one rotation per cycle while the output can take a result; cell 0 holds entry number cnt_r
        if (can_out) begin
          cell_op = cdq_pkg::CELL_SHL;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (dump_r) begin
            if (in_range) begin
              res.element   = cell_val[0];
              res.last      = (cnt_inc == occ_r);
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
          end else if (hit) begin
            found_nxt = 1'b1;
            pos_nxt   = cdq_pkg::POSITION_W'(cnt_inc);
          end
          if (cnt_r == CNT_W'(CAPACITY - 1)) begin
            state_nxt = cdq_pkg::S_IDLE;
            if (!dump_r) begin
              if (hit) begin
                res.position = cdq_pkg::POSITION_W'(cnt_inc);
              end else if (found_r) begin
                res.position = pos_r;
              end else begin
                res.status = cdq_pkg::STS_MISS;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
            end
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      dump_r      <= dump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the circular deque with search: directed table, random traffic, shadow deque.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  // A quiet stretch longer than this means the block hung. The slowest legal one is
  // a full-ring walk plus a long run of receiver stalls.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRILL_ROWS = 19;

  // Action codes the block has no use for; they must pass without a result.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  // One row of the directed table. Rows with typed set carry their single
  // expected status (or none, when silent); the rest go to the shadow deque.
  // A row with reps above one sends that many items, value stepping by one.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   value;
    logic [4:0]          reps;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic                silent;
  } drill_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  circular_deque_with_search_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the store: a ring with a front pointer and a fill count.
  logic signed [DATA_W-1:0] shadow_ring [CAP];
  int                       shadow_head = 0;
  int                       shadow_fill = 0;

  out_item_t owed_q [$];     // results owed by the block, oldest first
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 18;
  int        recv_stall_pct = 83;

  drill_row_t drill [DRILL_ROWS];

  function automatic void owe(input out_item_t res, input bit keep);
    if (keep) owed_q.push_back(res);
  endfunction

  // Advance the shadow deque by one item and, if keep is set, queue what the
  // block must answer.
  task automatic shadow_apply(input in_item_t it, input bit keep);
    out_item_t res;
    int        idx;
    int        hit;
    res = '0;
    res.last = 1'b1;
    case (it.action)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (shadow_fill >= CAP) begin
          res.status = STS_FULL;
        end else begin
          if (it.action == ACT_INS_FRONT) begin
            shadow_head = (shadow_head + CAP - 1) % CAP;
            shadow_ring[shadow_head] = it.value;
          end else begin
            shadow_ring[(shadow_head + shadow_fill) % CAP] = it.value;
          end
          shadow_fill++;
          res.status = STS_OK;
        end
        owe(res, keep);
      end
      ACT_DEL_FRONT, ACT_DEL_BACK: begin
        if (shadow_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          if (it.action == ACT_DEL_FRONT) shadow_head = (shadow_head + 1) % CAP;
          shadow_fill--;
          res.status = STS_OK;
        end
        owe(res, keep);
      end
      ACT_SEARCH: begin
        if (shadow_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          hit = 0;
          for (idx = 0; idx < shadow_fill; idx++)
            if (hit == 0 && shadow_ring[(shadow_head + idx) % CAP] == it.value) hit = idx + 1;
          res.status = (hit != 0) ? STS_OK : STS_MISS;
          res.position = hit[POSITION_W-1:0];
        end
        owe(res, keep);
      end
      ACT_DUMP: begin
        if (shadow_fill == 0) begin
          res.status = STS_EMPTY;
          owe(res, keep);
        end else begin
          for (idx = 0; idx < shadow_fill; idx++) begin
            res.status = STS_OK;
            res.element = shadow_ring[(shadow_head + idx) % CAP];
            res.last = (idx == shadow_fill - 1);
            owe(res, keep);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one item, idling first at the current sender rate, and hold it
  // until the block takes it. Starts at a falling edge, ends at the accepting
  // rising edge.
  task automatic send_item(input in_item_t it, input bit typed,
                           input logic [STATUS_W-1:0] typed_status, input bit silent);
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow_apply(it, !typed);
    if (typed && !silent) begin
      res = '0;
      res.status = typed_status;
      res.last = 1'b1;
      owed_q.push_back(res);
    end
  endtask

  // Small values dominate so searches hit and duplicates occur; extremes and
  // full-width values fill the rest.
  function automatic logic [DATA_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 11) - 6;
    if (pick == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Receiver side: stall at the current rate, decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checker and hang detector, sampled at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = out_data;
      if (owed_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: st=%0d el=%0d pos=%0d last=%0b",
                   got.status, got.element, got.position, got.last);
        fail_count++;
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.position !== want.position || got.last !== want.last) begin
          if (fail_count < 10)
            $display("mismatch: want st=%0d el=%0d pos=%0d last=%0b, got st=%0d el=%0d pos=%0d last=%0b",
                     want.status, want.element, want.position, want.last,
                     got.status, got.element, got.position, got.last);
          fail_count++;
        end
      end
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    in_item_t it;
    int       row;
    int       k;
    int       counted;
    int       roll;
    bit       filling;

    // Directed table. Empty-store cases first, then both extremes at both
    // ends, a hit and a miss, deletes at both ends, then fill to capacity with
    // a duplicate so the search must report the first match, overflow at both
    // ends, and a full-length dump.
    drill[0]  = {ACT_DEL_FRONT, 32'd0,         5'd1,  1'b1, STS_EMPTY, 1'b0};
    drill[1]  = {ACT_DEL_BACK,  32'd0,         5'd1,  1'b1, STS_EMPTY, 1'b0};
    drill[2]  = {ACT_SEARCH,    32'd0,         5'd1,  1'b1, STS_EMPTY, 1'b0};
    drill[3]  = {ACT_DUMP,      32'd0,         5'd1,  1'b1, STS_EMPTY, 1'b0};
    drill[4]  = {ACT_SPARE_LO,  32'hFFFF_FFFF, 5'd1,  1'b1, STS_OK,    1'b1};
    drill[5]  = {ACT_SPARE_HI,  32'd0,         5'd1,  1'b1, STS_OK,    1'b1};
    drill[6]  = {ACT_INS_FRONT, 32'h8000_0000, 5'd1,  1'b1, STS_OK,    1'b0};
    drill[7]  = {ACT_INS_BACK,  32'h7FFF_FFFF, 5'd1,  1'b1, STS_OK,    1'b0};
    drill[8]  = {ACT_INS_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b1, STS_OK,    1'b0};
    drill[9]  = {ACT_SEARCH,    32'h7FFF_FFFF, 5'd1,  1'b0, STS_OK,    1'b0};
    drill[10] = {ACT_SEARCH,    32'd0,         5'd1,  1'b0, STS_OK,    1'b0};
    drill[11] = {ACT_DEL_FRONT, 32'd0,         5'd1,  1'b1, STS_OK,    1'b0};
    drill[12] = {ACT_DEL_BACK,  32'd0,         5'd1,  1'b1, STS_OK,    1'b0};
    drill[13] = {ACT_INS_BACK,  32'd100,       5'd14, 1'b0, STS_OK,    1'b0};
    drill[14] = {ACT_INS_BACK,  32'd100,       5'd1,  1'b0, STS_OK,    1'b0};
    drill[15] = {ACT_INS_FRONT, 32'd1,         5'd1,  1'b1, STS_FULL,  1'b0};
    drill[16] = {ACT_INS_BACK,  32'd1,         5'd1,  1'b1, STS_FULL,  1'b0};
    drill[17] = {ACT_SEARCH,    32'd100,       5'd1,  1'b0, STS_OK,    1'b0};
    drill[18] = {ACT_DUMP,      32'd0,         5'd1,  1'b0, STS_OK,    1'b0};

    // Synchronous reset, released away from the rising edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First idling mode: slow receiver, mostly eager sender.
    for (row = 0; row < DRILL_ROWS; row++) begin
      for (k = 0; k < drill[row].reps; k++) begin
        it.action = drill[row].action;
        it.value = drill[row].value + k;
        send_item(it, drill[row].typed, drill[row].status, drill[row].silent);
      end
    end

    // Random traffic. The action mix swings between filling and draining
    // every 40 items so the store keeps passing through full and empty.
    counted = 0;
    filling = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == RANDOM_ITEMS / 3) begin
        send_idle_pct = 83;
        recv_stall_pct = 18;
      end else if (counted == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (counted % 40 == 0) filling = !filling;
      it.value = draw_value();
      if ($urandom_range(0, 99) < 3) begin
        // ignored by the block, so not counted
        it.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end else begin
        roll = $urandom_range(0, 99);
        if (filling) begin
          if (roll < 30)      it.action = ACT_INS_FRONT;
          else if (roll < 55) it.action = ACT_INS_BACK;
          else if (roll < 63) it.action = ACT_DEL_FRONT;
          else if (roll < 70) it.action = ACT_DEL_BACK;
          else if (roll < 90) it.action = ACT_SEARCH;
          else                it.action = ACT_DUMP;
        end else begin
          if (roll < 8)       it.action = ACT_INS_FRONT;
          else if (roll < 15) it.action = ACT_INS_BACK;
          else if (roll < 42) it.action = ACT_DEL_FRONT;
          else if (roll < 70) it.action = ACT_DEL_BACK;
          else if (roll < 90) it.action = ACT_SEARCH;
          else                it.action = ACT_DUMP;
        end
        counted++;
      end
      send_item(it, 1'b0, STS_OK, 1'b0);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then give a full ring walk more in case a stray result follows.
    while (owed_q.size() != 0) @(posedge clk);
    repeat (2 * CAP + 4) @(posedge clk);
    if (owed_q.size() != 0) fail_count++;

    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_with_search_top.sv
tb/tb_top.sv
